// ----- sv/tse_pkg.sv -----
// Shared types and constants for the tab-to-space expander.
`default_nettype none
package tse_pkg;

	localparam int DEF_EXPLICIT_STOPS = 5;
	localparam int DEF_COLUMN_BITS    = 12;

	// gap registers and their running sums (five gaps of up to 127)
	localparam int GAP_REGS = 5;
	localparam int GAP_W    = 7;
	localparam int SUM_W    = 10;
	localparam int CIDX_W   = 3;
	localparam int SCNT_W   = 3;

	localparam logic [GAP_W-1:0]  DEF_TAB_INC = 7'd8;
	localparam logic [GAP_W-1:0]  DEF_GAP     = 7'd8;
	localparam logic [SCNT_W-1:0] DEF_SCNT    = 3'd0;

	// longest blank run per tab, and the width of a run count
	localparam int RUN_MAX = 64;
	localparam int RUN_W   = 7;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] TAB_BYTE     = 8'd9;
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [7:0] BLANK_BYTE   = 8'd32;

	typedef enum logic [CIDX_W-1:0] {
		REG_TAB_INC    = 3'd0,
		REG_STOP_COUNT = 3'd1,
		REG_GAP_FIRST  = 3'd2,
		REG_GAP_SECOND = 3'd3,
		REG_GAP_THIRD  = 3'd4,
		REG_GAP_FOURTH = 3'd5,
		REG_GAP_FIFTH  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_SUMS,
		ST_PREP,
		ST_DIV,
		ST_RUN
	} front_state_t;

	// one queued word: the byte to emit and how many times
	typedef struct packed {
		logic [7:0]       ch;
		logic [RUN_W-1:0] count;
	} tse_word_t;

endpackage
`default_nettype wire

// ----- sv/tab_to_space_expander.sv -----
// Tab expander with a configurable tab stop list: top level.
//
// Input channel (in_valid, in_stall, in_char) takes one text byte per word.
// Output channel (out_valid, out_stall, out_char, last_of_run) gives one byte
// per word; last_of_run marks the final word caused by an input byte.
// A tab becomes 1 to 64 blanks toward the next stop beyond the column; a
// newline returns the column to zero; other bytes pass and advance it.
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while no byte is in flight.
//
// An input word reaches the output through the queue, the back end's word
// register and the output register. Throughput: one ordinary byte per cycle
// while nothing stalls; a tab holds the output side while it emits its blanks,
// and a four-word queue lets the input side keep taking bytes until it fills.
// After reset and after each config write, in_stall stays high through the
// ST_SUMS and ST_PREP states, and also through ST_DIV when the column lies
// beyond the last explicit stop (one remainder bit per cycle).
// A stalled output holds its word; the queue then fills and in_stall rises.
`default_nettype none
module tab_to_space_expander import tse_pkg::*; #(
	parameter int EXPLICIT_STOPS = DEF_EXPLICIT_STOPS,
	parameter int COLUMN_BITS    = DEF_COLUMN_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [GAP_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        in_char,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             out_char,
	output logic                   last_of_run
);

	tse_word_t push_word, head;
	logic      push, full, pop, empty;

	assign cfg_ready = 1'b1;

	tse_front #(
		.EXPLICIT_STOPS(EXPLICIT_STOPS),
		.COLUMN_BITS   (COLUMN_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_char  (in_char),
		.in_stall (in_stall),
		.q_full   (full),
		.push     (push),
		.push_word(push_word)
	);

	tse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_word(push_word),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	tse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (empty),
		.q_head     (head),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.last_of_run(last_of_run)
	);

endmodule
`default_nettype wire

// ----- sv/tse_rem.sv -----
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none
module tse_rem import tse_pkg::*; #(
	parameter int DIVIDEND_W = DEF_COLUMN_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [GAP_W-1:0]      divisor,
	output logic                       done,
	output logic [GAP_W-1:0]           rem
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [GAP_W-1:0]      dvs_q;
	logic [GAP_W-1:0]      rem_q;
	logic [GAP_W:0]        trial;

	assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= GAP_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[GAP_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ----- sv/tse_front.sv -----
// Front end: configuration, column and tab stop tracking, run length per byte.
`default_nettype none
module tse_front import tse_pkg::*; #(
	parameter int EXPLICIT_STOPS = DEF_EXPLICIT_STOPS,
	parameter int COLUMN_BITS    = DEF_COLUMN_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [GAP_W-1:0]  cfg_data,
	input  wire logic              in_valid,
	input  wire logic [7:0]        in_char,
	output logic                   in_stall,
	input  wire logic              q_full,
	output logic                   push,
	output tse_word_t              push_word
);

	localparam int NSTOP  = (EXPLICIT_STOPS < GAP_REGS) ? EXPLICIT_STOPS : GAP_REGS;
	localparam int STOP_W = (COLUMN_BITS + 1 > SUM_W) ? COLUMN_BITS + 1 : SUM_W;
	localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

	front_state_t state_q, state_d;

	logic [GAP_W-1:0]  tab_inc_q;
	logic [SCNT_W-1:0] stop_count_q;
	logic [GAP_W-1:0]  gap_q [GAP_REGS];

	logic [SUM_W-1:0]  sum_c  [GAP_REGS];
	logic [SUM_W-1:0]  psum_q [GAP_REGS];
	logic [SCNT_W-1:0] n_c, n_q;
	logic [SUM_W-1:0]  pn_c, pn_q;

	logic [COLUMN_BITS-1:0] col_q, col_nx;
	logic [STOP_W-1:0]      rep_q, rep_nx;

	logic [GAP_W-1:0]  inc_c;
	logic [STOP_W-1:0] col_ext, pn_ext, inc_ext, nx_ext;
	logic [STOP_W-1:0] exp_stop, stop_c, diff;
	logic              found;
	logic [RUN_W-1:0]  nb_c;
	logic [COLUMN_BITS:0] col_sum;
	logic              is_tab, is_nl, col_le_pn;
	logic              ready, accept, div_start, div_done;
	logic [GAP_W-1:0]  div_rem;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_inc_q    <= DEF_TAB_INC;
			stop_count_q <= DEF_SCNT;
			for (int k = 0; k < GAP_REGS; k++) begin
				gap_q[k] <= DEF_GAP;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAB_INC:    tab_inc_q    <= cfg_data;
				REG_STOP_COUNT: stop_count_q <= cfg_data[SCNT_W-1:0];
				REG_GAP_FIRST:  gap_q[0]     <= cfg_data;
				REG_GAP_SECOND: gap_q[1]     <= cfg_data;
				REG_GAP_THIRD:  gap_q[2]     <= cfg_data;
				REG_GAP_FOURTH: gap_q[3]     <= cfg_data;
				REG_GAP_FIFTH:  gap_q[4]     <= cfg_data;
				default: ;
			endcase
		end
	end

	// explicit stop columns as running sums of the gaps
	always_comb begin
		logic [SUM_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < GAP_REGS; k++) begin
			acc      = acc + SUM_W'(gap_q[k]);
			sum_c[k] = acc;
		end
	end

	assign n_c   = (stop_count_q > SCNT_W'(NSTOP)) ? SCNT_W'(NSTOP) : stop_count_q;
	assign pn_c  = (n_c == '0) ? '0 : sum_c[n_c - 1'b1];
	assign inc_c = (tab_inc_q == '0) ? GAP_W'(1) : tab_inc_q;

	always_ff @(posedge clk) begin
		psum_q <= sum_c;
		n_q    <= n_c;
		pn_q   <= pn_c;
	end

	assign col_ext   = STOP_W'(col_q);
	assign pn_ext    = STOP_W'(pn_q);
	assign inc_ext   = STOP_W'(inc_c);
	assign col_le_pn = (col_ext <= pn_ext);

	// first explicit stop beyond the column, else the repeating stop
	always_comb begin
		found    = 1'b0;
		exp_stop = '0;
		for (int k = 0; k < GAP_REGS; k++) begin
			if (!found && (SCNT_W'(k) < n_q) && (STOP_W'(psum_q[k]) > col_ext)) begin
				found    = 1'b1;
				exp_stop = STOP_W'(psum_q[k]);
			end
		end
	end

	assign stop_c = found ? exp_stop : rep_q;
	assign diff   = stop_c - col_ext;
	assign nb_c   = (diff > STOP_W'(RUN_MAX)) ? RUN_W'(RUN_MAX) : diff[RUN_W-1:0];

	assign is_tab  = (in_char == TAB_BYTE);
	assign is_nl   = (in_char == NEWLINE_BYTE);
	assign col_sum = {1'b0, col_q} + (COLUMN_BITS+1)'(nb_c);

	always_comb begin
		if (is_tab) begin
			col_nx = (col_sum > {1'b0, COL_MAX}) ? COL_MAX : col_sum[COLUMN_BITS-1:0];
		end else if (is_nl) begin
			col_nx = '0;
		end else if (col_q == COL_MAX) begin
			col_nx = col_q;
		end else begin
			col_nx = col_q + 1'b1;
		end
	end

	// repeating stop: rearm at or before the last explicit stop, step on landing
	assign nx_ext = STOP_W'(col_nx);
	always_comb begin
		if (nx_ext <= pn_ext) begin
			rep_nx = pn_ext + inc_ext;
		end else if (nx_ext == rep_q) begin
			rep_nx = rep_q + inc_ext;
		end else begin
			rep_nx = rep_q;
		end
	end

	// recompute the repeating stop after reset and every register write
	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = ST_SUMS;
		end else begin
			unique case (state_q)
				ST_SUMS: state_d = ST_PREP;
				ST_PREP: state_d = col_le_pn ? ST_RUN : ST_DIV;
				ST_DIV:  state_d = div_done ? ST_RUN : ST_DIV;
				ST_RUN:  state_d = ST_RUN;
				default: state_d = ST_SUMS;
			endcase
		end
	end

	always_comb begin
		ready     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_SUMS: ;
			ST_PREP: div_start = !col_le_pn;
			ST_DIV:  ;
			ST_RUN:  ready = !q_full;
			default: ;
		endcase
	end

	tse_rem #(
		.DIVIDEND_W(COLUMN_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(COLUMN_BITS'(col_ext - pn_ext)),
		.divisor (inc_c),
		.done    (div_done),
		.rem     (div_rem)
	);

	assign accept = in_valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SUMS;
			col_q   <= '0;
			rep_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				col_q <= col_nx;
				rep_q <= rep_nx;
			end else if (state_q == ST_PREP && col_le_pn) begin
				rep_q <= pn_ext + inc_ext;
			end else if (state_q == ST_DIV && div_done) begin
				rep_q <= col_ext + inc_ext - STOP_W'(div_rem);
			end
		end
	end

	assign in_stall        = !ready;
	assign push            = accept;
	assign push_word.ch    = is_tab ? BLANK_BYTE : in_char;
	assign push_word.count = is_tab ? nb_c : RUN_W'(1);

endmodule
`default_nettype wire

// ----- sv/tse_queue.sv -----
// Short word queue between the front and back ends.
`default_nettype none
module tse_queue import tse_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire tse_word_t push_word,
	output logic           full,
	input  wire logic      pop,
	output logic           empty,
	output tse_word_t      head
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	tse_word_t       mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	// pointers wrap naturally: depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_word;
	end

	assign full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

endmodule
`default_nettype wire

// ----- sv/tse_back.sv -----
// Back end: expand queued words into output bytes behind an output register.
`default_nettype none
module tse_back import tse_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      q_empty,
	input  wire tse_word_t q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  wire logic      out_stall,
	output logic [7:0]     out_char,
	output logic           last_of_run
);

	tse_word_t cur_q;
	logic      cur_v_q;
	logic      out_v_q;
	logic [7:0] out_char_q;
	logic      last_q;
	logic      slot_free, emit, finish;

	assign slot_free = !out_v_q || !out_stall;
	assign emit      = cur_v_q && slot_free;
	assign finish    = emit && (cur_q.count == RUN_W'(1));
	assign q_pop     = (!cur_v_q || finish) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_v_q <= 1'b1;
			end else if (finish) begin
				cur_v_q <= 1'b0;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (slot_free) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end else if (emit) begin
			cur_q.count <= cur_q.count - 1'b1;
		end
		if (emit) begin
			out_char_q <= cur_q.ch;
			last_q     <= (cur_q.count == RUN_W'(1));
		end
	end

	assign out_valid   = out_v_q;
	assign out_char    = out_char_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

// ----- sv/tse_checker.sv -----
// Port-level assertions for the tab expander and their bind.
`default_nettype none
module tse_checker import tse_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cfg_valid,
	input wire logic              cfg_ready,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [7:0]        out_char,
	input wire logic              last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_of_run))
		else $error("output word changed while stalled");

	// only tab runs produce more than one word, and those are all blanks
	a_mid_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> out_char == BLANK_BYTE)
		else $error("non-final word is not a blank");

	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("blank run interrupted");

	a_cfg_recompute: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("input taken before stops were recomputed");

endmodule

bind tab_to_space_expander tse_checker u_tse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_char   (out_char),
	.last_of_run(last_of_run)
);
`default_nettype wire
